// ----- design/tvstg_pkg.sv -----
// Shared types and constants for the two-voice square tone generator.
`default_nettype none
package tvstg_pkg;

  localparam int NOTE_W   = 8;
  localparam int COUNT_W  = 24;
  localparam int PERIOD_W = 24;
  localparam int DUE_W    = 25;
  localparam int ROM_W    = 17;
  localparam int LEVEL_W  = 8;

  // kind field codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // register word addresses
  localparam logic CFG_INTERVAL = 1'b0;

  localparam logic [COUNT_W-1:0] INTERVAL_RESET = 24'd31250;

  localparam logic [LEVEL_W-1:0] LEVEL_BASE = 8'h40;
  localparam int                 LEVEL_SHIFT = 6;

  // pitch table: period(n) = floor(2^((ROOT_NOTE-n)/12) * 1e6 / ROOT_HZ)
  localparam int ROOT_NOTE = 69;
  localparam int OCTAVE_SPAN = 5;
  localparam longint unsigned DEN_BASE = 64'd440000000000;
  localparam longint unsigned SEMITONE_RATIO [12] = '{
    64'd1000000000000000, 64'd1059463094359295, 64'd1122462048309373,
    64'd1189207115002721, 64'd1259921049894873, 64'd1334839854170034,
    64'd1414213562373095, 64'd1498307076876681, 64'd1587401051968199,
    64'd1681792830507429, 64'd1781797436280678, 64'd1887748625363386
  };

  typedef struct packed {
    logic load;
    logic step;
  } voice_ctl_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               playing;
    logic               last_tick;
  } result_t;

endpackage
`default_nettype wire

// ----- design/tvstg_cmd_if.sv -----
// Command channel: load or tick transactions.
`default_nettype none
interface tvstg_cmd_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [tvstg_pkg::NOTE_W-1:0] note_first;
  logic [tvstg_pkg::NOTE_W-1:0] note_second;

  modport source (output valid, kind, note_first, note_second, input ready);
  modport sink   (input valid, kind, note_first, note_second, output ready);
endinterface
`default_nettype wire

// ----- design/tvstg_sample_if.sv -----
// Sample channel: one transaction per tick.
`default_nettype none
interface tvstg_sample_if;
  logic                          valid;
  logic                          ready;
  logic [tvstg_pkg::LEVEL_W-1:0] level;
  logic                          playing;
  logic                          last_tick;

  modport source (output valid, level, playing, last_tick, input ready);
  modport sink   (input valid, level, playing, last_tick, output ready);
endinterface
`default_nettype wire

// ----- design/tvstg_voice.sv -----
// One square-wave voice: due-time compare, toggle and period advance.
`default_nettype none
module tvstg_voice (
  input  wire                                clk,
  input  wire                                rst,
  input  tvstg_pkg::voice_ctl_t              ctl,
  input  wire  [tvstg_pkg::PERIOD_W-1:0]     period_load,
  input  wire  [tvstg_pkg::COUNT_W-1:0]      tick_count,
  output logic                               level_next
);

  logic [tvstg_pkg::PERIOD_W-1:0] period;
  logic [tvstg_pkg::DUE_W-1:0]    due;
  logic                           level;
  logic                           goes_high;

  logic hit;
  assign hit        = ctl.step && ({1'b0, tick_count} == due);
  assign level_next = hit ? goes_high : level;

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= '0;
      due       <= '0;
      level     <= 1'b0;
      goes_high <= 1'b0;
    end else if (ctl.load) begin
      // level is kept across loads; first toggle writes LOW
      period    <= period_load;
      due       <= {1'b0, period_load};
      goes_high <= 1'b0;
    end else if (hit) begin
      level     <= goes_high;
      goes_high <= ~goes_high;
      due       <= due + {1'b0, period};
    end
  end

endmodule
`default_nettype wire

// ----- design/two_voice_square_tone_generator.sv -----
// Top level of the two-voice square tone generator.
// A load transaction (kind 0) picks a note per voice and restarts an interval of
// interval_us ticks; it yields no sample. A tick transaction (kind 1) yields one
// sample: the merged level of both voices (64, 128 or 192), whether the tick lay
// inside an active interval, and a flag on the interval's final tick so the host
// can send the next note pair. Notes above 127 are rests and hold their level.
// The voice compare/add and the interval counter update in the same cycle a
// transaction is accepted, so one command can be taken per clock while cmd.ready
// is high. Samples leave through an output register backed by a one-entry skid
// buffer, so commands keep flowing while a sample waits; cmd.ready drops only
// when both are full. interval_us sits at byte address 0 of the APB port and
// should be written only while no tick is in flight.
`default_nettype none
module two_voice_square_tone_generator #(
  parameter int NOTE_COUNT = 128
) (
  input  wire                                clk,
  input  wire                                rst,
  tvstg_cmd_if.sink                          cmd,
  tvstg_sample_if.source                     sample,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [2:0]                         paddr,
  input  wire  [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int IDX_W = $clog2(NOTE_COUNT);

  // ---------------------------------------------------------------------------
  // Pitch ROM, worked out at elaboration.
  // ---------------------------------------------------------------------------
  logic [tvstg_pkg::ROM_W-1:0] period_rom [NOTE_COUNT];

  for (genvar i = 0; i < NOTE_COUNT; i++) begin : g_rom
    localparam int SHIFTED = tvstg_pkg::ROOT_NOTE + 12 * tvstg_pkg::OCTAVE_SPAN - i;
    localparam int Q = SHIFTED / 12 - tvstg_pkg::OCTAVE_SPAN;
    localparam int R = SHIFTED % 12;
    localparam int SH_UP = (Q >= 0) ? Q : 0;
    localparam int SH_DN = (Q >= 0) ? 0 : -Q;
    localparam longint unsigned NUM = tvstg_pkg::SEMITONE_RATIO[R] << SH_UP;
    localparam longint unsigned DEN = tvstg_pkg::DEN_BASE << SH_DN;
    localparam longint unsigned PER = NUM / DEN;
    assign period_rom[i] = PER[tvstg_pkg::ROM_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------------
  logic [tvstg_pkg::COUNT_W-1:0] interval_us;
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == tvstg_pkg::CFG_INTERVAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_us <= tvstg_pkg::INTERVAL_RESET;
    end else if (cfg_wr) begin
      interval_us <= pwdata[tvstg_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tvstg_pkg::CFG_INTERVAL) begin
      prdata = {8'd0, interval_us};
    end
  end

  // ---------------------------------------------------------------------------
  // Command acceptance and interval control.
  // ---------------------------------------------------------------------------
  logic ov, sv;                 // output register / skid entry occupied
  tvstg_pkg::result_t od, sd;

  logic accept, is_load, is_tick;
  assign cmd.ready = !sv;
  assign accept    = cmd.valid && cmd.ready;
  assign is_load   = accept && (cmd.kind == tvstg_pkg::KIND_LOAD);
  assign is_tick   = accept && (cmd.kind == tvstg_pkg::KIND_TICK);

  logic [tvstg_pkg::COUNT_W-1:0] tick_count, tick_count_next;
  logic                          active;
  logic                          interval_end;

  assign tick_count_next = tick_count + 1'b1;
  // a wrapped counter also closes the interval
  assign interval_end = (tick_count_next >= interval_us) || (tick_count_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      active     <= 1'b0;
    end else if (is_load) begin
      tick_count <= '0;
      active     <= (interval_us != '0);
    end else if (is_tick && active) begin
      tick_count <= tick_count_next;
      if (interval_end) begin
        active <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Voices.
  // ---------------------------------------------------------------------------
  function automatic logic [tvstg_pkg::PERIOD_W-1:0] pick_period(
    input logic [tvstg_pkg::NOTE_W-1:0]  note,
    input logic [tvstg_pkg::ROM_W-1:0]   rom_val,
    input logic [tvstg_pkg::COUNT_W-1:0] rest_len
  );
    // rest: due time lands at the interval end, so the level holds
    if (32'(note) >= NOTE_COUNT) return rest_len;
    return tvstg_pkg::PERIOD_W'(rom_val);
  endfunction

  tvstg_pkg::voice_ctl_t         voice_ctl;
  logic [tvstg_pkg::PERIOD_W-1:0] period_first, period_second;
  logic                           level_first, level_second;

  assign voice_ctl.load = is_load;
  assign voice_ctl.step = is_tick && active;

  assign period_first  = pick_period(cmd.note_first,
                                     period_rom[cmd.note_first[IDX_W-1:0]], interval_us);
  assign period_second = pick_period(cmd.note_second,
                                     period_rom[cmd.note_second[IDX_W-1:0]], interval_us);

  tvstg_voice u_voice_first (
    .clk         (clk),
    .rst         (rst),
    .ctl         (voice_ctl),
    .period_load (period_first),
    .tick_count  (tick_count),
    .level_next  (level_first)
  );

  tvstg_voice u_voice_second (
    .clk         (clk),
    .rst         (rst),
    .ctl         (voice_ctl),
    .period_load (period_second),
    .tick_count  (tick_count),
    .level_next  (level_second)
  );

  // ---------------------------------------------------------------------------
  // Sample formation and output buffering.
  // ---------------------------------------------------------------------------
  tvstg_pkg::result_t res;
  logic [1:0]         high_count;

  assign high_count    = {1'b0, level_first} + {1'b0, level_second};
  assign res.level     = tvstg_pkg::LEVEL_BASE
                       + (tvstg_pkg::LEVEL_W'(high_count) << tvstg_pkg::LEVEL_SHIFT);
  assign res.playing   = active;
  assign res.last_tick = active && interval_end;

  logic pop;
  assign pop = ov && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else begin
      if (pop) begin
        if (sv) begin
          ov <= 1'b1;
          sv <= 1'b0;
        end else begin
          ov <= is_tick;
        end
      end else if (is_tick) begin
        if (!ov) begin
          ov <= 1'b1;
        end else begin
          sv <= 1'b1;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (pop && sv) begin
      od <= sd;
    end else if (is_tick && (pop || !ov)) begin
      od <= res;
    end
    if (is_tick && ov && !pop) begin
      sd <= res;
    end
  end

  assign sample.valid     = ov;
  assign sample.level     = od.level;
  assign sample.playing   = od.playing;
  assign sample.last_tick = od.last_tick;

endmodule
`default_nettype wire
